@@ src/ygghm_pkg.sv @@
// Shared constants and types for the yaw glitch gate / hysteresis map block.
package ygghm_pkg;

  localparam int ANGLE_FRAC_BITS = 7;

  typedef logic signed [17:0] ang_t;

  localparam ang_t DEG_90  = 18'(90 << ANGLE_FRAC_BITS);
  localparam ang_t DEG_160 = 18'(160 << ANGLE_FRAC_BITS);
  localparam ang_t DEG_180 = 18'(180 << ANGLE_FRAC_BITS);
  localparam ang_t DEG_200 = 18'(200 << ANGLE_FRAC_BITS);
  localparam ang_t DEG_360 = 18'(360 << ANGLE_FRAC_BITS);

  // Full scale is 400 degrees = 2^(ANGLE_FRAC_BITS+4) * 25.
  localparam int DIV_SHIFT = ANGLE_FRAC_BITS + 4;
  // Bias keeps the divide-by-25 operand positive; BIAS/25 = 2^16 drops out mod 2^16.
  localparam logic signed [22:0] DIV_BIAS = 23'(25 * 65536);
  localparam int RECIP_SHIFT = 27;
  localparam logic [22:0] RECIP_MUL = 23'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_CAPTURE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_GATE_ENABLE = 2'd0,
    REG_MAX_STEP    = 2'd1,
    REG_DAC_LOW     = 2'd2,
    REG_DAC_HIGH    = 2'd3
  } reg_idx_e;

  // Result fields carried down the scaling pipeline.
  typedef struct packed {
    logic              ok;
    logic              resync;
    logic signed [15:0] adj;
    logic signed [15:0] ext;
    logic              low_mode;
    logic [15:0]       count;
  } res_t;

endpackage

@@ src/yaw_glitch_gate_hysteresis_map.sv @@
// Top level: yaw glitch gate, heading offset, hysteresis range map and DAC scaling.
//
// Input channel (in_valid_i/in_ready_o): opcode_i selects a yaw sample (yaw_in_i,
// signed 1/128 degree) or a capture of the last yaw as heading offset.
// Output channel (out_valid_o/out_ready_i): exactly one result per input
// transaction, in order: gate decision, resync flag, adjusted and extended yaw,
// range mode, DAC code and saturating glitch count.
// Configuration goes through the APB port (4 registers at byte addresses 0,4,8,12);
// write it only while the block is idle.
// Pipeline: input register, state/angle stage, product multiply, reciprocal
// multiply for the /51200 floor, output register. One transaction per cycle is
// sustained while the receiver does not stall the output.
// Throughput is set by the two multiplier stages, each one product per cycle.
// When the receiver stalls, results back up stage by stage; bubbles are squeezed
// out, so the input keeps accepting until every stage is full.
// Reset: registers go to their defaults (max_step 1280, dac_high 4095, others 0),
// low range mode is set, stability flags, last yaw, offset and glitch count clear.
module yaw_glitch_gate_hysteresis_map
  import ygghm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [15:0] yaw_in_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_ok_o,
  output logic               resync_request_o,
  output logic signed [15:0] adjusted_yaw_o,
  output logic signed [15:0] extended_yaw_o,
  output logic               low_range_mode_o,
  output logic [15:0]        dac_code_o,
  output logic [15:0]        glitch_count_o,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- configuration ----------------
  logic        gate_en_q;
  logic [14:0] max_step_q;
  logic [15:0] dac_low_q, dac_high_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_en_q  <= 1'b0;
      max_step_q <= 15'd1280;
      dac_low_q  <= 16'd0;
      dac_high_q <= 16'd4095;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GATE_ENABLE: gate_en_q  <= pwdata[0];
        REG_MAX_STEP:    max_step_q <= pwdata[14:0];
        REG_DAC_LOW:     dac_low_q  <= pwdata[15:0];
        REG_DAC_HIGH:    dac_high_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GATE_ENABLE: prdata = {31'd0, gate_en_q};
      REG_MAX_STEP:    prdata = {17'd0, max_step_q};
      REG_DAC_LOW:     prdata = {16'd0, dac_low_q};
      REG_DAC_HIGH:    prdata = {16'd0, dac_high_q};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic en0, en1, en2, en3, en4;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o  = en0;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 0: input register ----------------
  op_e               s0_op_q;
  logic signed [15:0] s0_yaw_q;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      s0_op_q  <= op_e'(opcode_i);
      s0_yaw_q <= yaw_in_i;
    end
  end

  // ---------------- stage 1: gate, offset, hysteresis ----------------
  logic signed [15:0] last_yaw_q, last_yaw_d;
  logic signed [15:0] offset_q, offset_d;
  logic               stable_q, stable_d;
  logic               low_mode_q, low_mode_d;
  logic [15:0]        count_q, count_d;

  ang_t        y_s, step, abs_step, mod_step, circ, wrap_in, adj_w, ext_w;
  logic        stable_new, ok, resync, lm_next;
  res_t        s1_res, s1_res_q;
  logic [15:0] s1_p, s1_p_q;
  logic signed [16:0] s1_span, s1_span_q;
  logic        adv1;

  assign adv1 = v0_q && en1;

  always_comb begin
    y_s      = {{2{s0_yaw_q[15]}}, s0_yaw_q};
    step     = y_s - {{2{last_yaw_q[15]}}, last_yaw_q};
    abs_step = step[17] ? -step : step;
    mod_step = (abs_step >= DEG_360) ? abs_step - DEG_360 : abs_step;
    circ     = (mod_step > DEG_180) ? DEG_360 - mod_step : mod_step;
    stable_new = circ <= $signed({3'b000, max_step_q});

    resync = gate_en_q && stable_q && !stable_new;
    ok     = !gate_en_q || (stable_q && stable_new);

    wrap_in = y_s - {{2{offset_q[15]}}, offset_q};
    if (wrap_in > DEG_180) begin
      adj_w = wrap_in - DEG_360;
    end else if (wrap_in <= -DEG_180) begin
      adj_w = wrap_in + DEG_360;
    end else begin
      adj_w = wrap_in;
    end

    lm_next = low_mode_q;
    if (low_mode_q) begin
      if (adj_w > DEG_90 && adj_w < DEG_160) lm_next = 1'b0;
    end else begin
      if (adj_w < -DEG_90 && adj_w > -DEG_160) lm_next = 1'b1;
    end

    if (lm_next) begin
      ext_w = (adj_w > DEG_160) ? adj_w - DEG_360 : adj_w;
    end else begin
      ext_w = (adj_w <= -DEG_160) ? adj_w + DEG_360 : adj_w;
    end

    // state next values
    last_yaw_d = last_yaw_q;
    offset_d   = offset_q;
    stable_d   = stable_q;
    low_mode_d = low_mode_q;
    count_d    = count_q;
    s1_res     = '0;
    s1_p       = 16'd0;
    if (s0_op_q == OP_CAPTURE) begin
      offset_d = last_yaw_q;
    end else begin
      last_yaw_d = s0_yaw_q;
      stable_d   = stable_new && !resync;
      if (resync && count_q != CNT_MAX) count_d = count_q + 16'd1;
      if (ok) begin
        low_mode_d = lm_next;
        s1_res.adj = adj_w[15:0];
        s1_res.ext = ext_w[15:0];
        s1_p       = 16'(ext_w + DEG_200);
      end
      s1_res.ok     = ok;
      s1_res.resync = resync;
    end
    s1_res.low_mode = low_mode_d;
    s1_res.count    = count_d;
    s1_span = $signed({1'b0, dac_high_q}) - $signed({1'b0, dac_low_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_yaw_q <= '0;
      offset_q   <= '0;
      stable_q   <= 1'b0;
      low_mode_q <= 1'b1;
      count_q    <= '0;
    end else if (adv1) begin
      last_yaw_q <= last_yaw_d;
      offset_q   <= offset_d;
      stable_q   <= stable_d;
      low_mode_q <= low_mode_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_res_q  <= s1_res;
      s1_p_q    <= s1_p;
      s1_span_q <= s1_span;
    end
  end

  // ---------------- stage 2: (ext + 200 deg) * (dac_high - dac_low) ----------------
  res_t               s2_res_q;
  logic signed [33:0] s2_num_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_res_q <= s1_res_q;
      s2_num_q <= $signed({1'b0, s1_p_q}) * s1_span_q;
    end
  end

  // ---------------- stage 3: floor divide by 400 deg ----------------
  // floor(n / (2^k * 25)) = floor(floor(n / 2^k) / 25); the /25 is a reciprocal multiply
  logic signed [22:0] s3_x, s3_u;
  logic [44:0]        s3_prod;
  res_t               s3_res_q;
  logic [15:0]        s3_q_q;

  always_comb begin
    s3_x    = 23'(s2_num_q >>> DIV_SHIFT);
    s3_u    = s3_x + DIV_BIAS;
    s3_prod = 45'(s3_u[21:0]) * 45'(RECIP_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_res_q <= s2_res_q;
      s3_q_q   <= s3_prod[RECIP_SHIFT +: 16];
    end
  end

  // ---------------- stage 4: output register ----------------
  res_t        s4_res_q;
  logic [15:0] s4_dac_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_res_q <= s3_res_q;
      s4_dac_q <= s3_res_q.ok ? dac_low_q + s3_q_q : 16'd0;
    end
  end

  assign sample_ok_o      = s4_res_q.ok;
  assign resync_request_o = s4_res_q.resync;
  assign adjusted_yaw_o   = s4_res_q.adj;
  assign extended_yaw_o   = s4_res_q.ext;
  assign low_range_mode_o = s4_res_q.low_mode;
  assign dac_code_o       = s4_dac_q;
  assign glitch_count_o   = s4_res_q.count;

endmodule
